### rtl/pdbm_pkg.sv
// shared types, constants and log table functions for the pauli dB pixel mapper
`default_nettype none
package pdbm_pkg;

    // number of register stages from input beat to output beat
    localparam int PIPE_DEPTH = 6;

    // widths of the dB datapath
    localparam int TAB_W  = 10;   // log table entry, at most 771
    localparam int DB_W   = 18;   // raw octave plus table sum, signed
    localparam int CFG_W  = 16;   // Q8.8 dB registers
    localparam int SCL_W  = 24;   // Q16 scale factor
    localparam int DIFF_W = 16;   // clamped dB minus lower limit
    localparam int PROD_W = DIFF_W + SCL_W;
    localparam int LVL_W  = 8;

    // Q8.8 dB per octave, 10*log10(2) scaled by 256
    localparam logic signed [DB_W-1:0] DB_PER_OCTAVE = 18'sd771;
    localparam logic signed [9:0]      EXP_BIAS      = 10'sd127;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DB   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DB   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_DB = 2'd3;

    // display window shared by the three lanes
    typedef struct packed {
        logic signed [CFG_W-1:0] min_db;
        logic signed [CFG_W-1:0] max_db;
        logic        [SCL_W-1:0] scale_factor;
        logic signed [CFG_W-1:0] floor_db;
    } win_cfg_t;

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    // fractional log2 of m in [1,2), Q30 in and out, by repeated squaring
    // used only while elaborating the table
    function automatic logic [63:0] log2_frac(input logic [63:0] m_in);
        logic [63:0] m;
        logic [63:0] r;
        begin
            m = m_in;
            r = 64'd0;
            for (int i = 0; i < 30; i++) begin
                m = (m * m) >> 30;
                r = r << 1;
                if (m >= (Q30_ONE << 1)) begin
                    m = m >> 1;
                    r = r | 64'd1;
                end
            end
            return r;
        end
    endfunction

    // log2(10) in Q30, doubled for the rounding division
    localparam logic [63:0] LOG_DEN  = 3 * Q30_ONE + log2_frac(64'd5 << 28);
    localparam logic [63:0] LOG_DEN2 = 2 * LOG_DEN;

    // round(2560*log10(1+k/2^n)) for one table entry
    function automatic logic [TAB_W-1:0] log_tab_entry(input int unsigned k, input int n);
        logic [63:0] m;
        logic [63:0] num;
        begin
            m   = Q30_ONE + (64'(k) << (30 - n));
            num = 64'd2560 * log2_frac(m);
            return TAB_W'((2 * num + LOG_DEN) / LOG_DEN2);
        end
    endfunction

endpackage
`default_nettype wire

### rtl/pauli_db_rgb_pixel_mapper.sv
// an accepted input beat passes through stage registers 0 to 5 on its way to its output beat
// throughput: one pixel per cycle while the output is not stalled, set by the six-stage lane pipeline
// the log table is a constant rom read in stage 1 of each lane
// backpressure stalls only the stages that are full, bubbles are squeezed out
// reset clears all stage valid bits and loads the default display window
`default_nettype none
module pauli_db_rgb_pixel_mapper #(
    parameter int LOG_TABLE_BITS = 10
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration write port
    input  wire logic                              cfg_we,
    input  wire logic [pdbm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pdbm_pkg::SCL_W-1:0]        cfg_data,
    // pixel input channel
    input  wire logic                              item_valid,
    output logic                                   item_ready,
    input  wire logic [31:0]                       t11_bits,
    input  wire logic [31:0]                       t22_bits,
    input  wire logic [31:0]                       t33_bits,
    input  wire logic                              pixel_valid,
    // color output channel
    output logic                                   result_valid,
    input  wire logic                              result_ready,
    output logic      [7:0]                        blue,
    output logic      [7:0]                        green,
    output logic      [7:0]                        red
);
    import pdbm_pkg::*;

    // display window registers
    win_cfg_t win_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg.min_db       <= -16'sd7680;
            win_reg.max_db       <= 16'sd0;
            win_reg.scale_factor <= 24'd2176;
            win_reg.floor_db     <= -16'sd32768;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN_DB:   win_reg.min_db       <= cfg_data[CFG_W-1:0];
                CFG_MAX_DB:   win_reg.max_db       <= cfg_data[CFG_W-1:0];
                CFG_SCALE:    win_reg.scale_factor <= cfg_data;
                CFG_FLOOR_DB: win_reg.floor_db     <= cfg_data[CFG_W-1:0];
                default:      win_reg.floor_db     <= win_reg.floor_db;
            endcase
        end
    end

    // per-stage advance: a stage loads when it is empty or its successor moves
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [PIPE_DEPTH-1:0] stage_en;

    always_comb
    begin
        stage_en[PIPE_DEPTH-1] = !vld_reg[PIPE_DEPTH-1] || result_ready;
        for (int s = PIPE_DEPTH - 2; s >= 0; s--)
            stage_en[s] = !vld_reg[s] || stage_en[s + 1];
    end

    assign item_ready   = stage_en[0];
    assign result_valid = vld_reg[PIPE_DEPTH-1];

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (stage_en[0])
                vld_reg[0] <= item_valid;
            for (int s = 1; s < PIPE_DEPTH; s++)
                if (stage_en[s])
                    vld_reg[s] <= vld_reg[s - 1];
        end
    end

    // pixel mask rides alongside the lanes
    logic [PIPE_DEPTH-1:0] mask_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
            mask_reg[0] <= pixel_valid;
        for (int s = 1; s < PIPE_DEPTH; s++)
            if (stage_en[s])
                mask_reg[s] <= mask_reg[s - 1];
    end

    // three color lanes
    logic [LVL_W-1:0] lvl_b;
    logic [LVL_W-1:0] lvl_g;
    logic [LVL_W-1:0] lvl_r;

    pdbm_lane #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_lane_b (
        .clk      (clk),
        .stage_en (stage_en),
        .win      (win_reg),
        .t_bits   (t11_bits),
        .level    (lvl_b)
    );

    pdbm_lane #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_lane_g (
        .clk      (clk),
        .stage_en (stage_en),
        .win      (win_reg),
        .t_bits   (t33_bits),
        .level    (lvl_g)
    );

    pdbm_lane #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_lane_r (
        .clk      (clk),
        .stage_en (stage_en),
        .win      (win_reg),
        .t_bits   (t22_bits),
        .level    (lvl_r)
    );

    // masked pixels come out black
    assign blue  = mask_reg[PIPE_DEPTH-1] ? lvl_b : '0;
    assign green = mask_reg[PIPE_DEPTH-1] ? lvl_g : '0;
    assign red   = mask_reg[PIPE_DEPTH-1] ? lvl_r : '0;

    // an accepted input beat occupies the first stage next cycle
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> vld_reg[0])
        else $error("accepted beat did not enter the first stage");

    // a pipeline with any empty stage must take input
    a_room_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !(&vld_reg) |-> item_ready)
        else $error("input stalled while the pipeline has a hole");

    // a stalled output beat stays in the last stage
    a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(mask_reg[PIPE_DEPTH-1]))
        else $error("stalled output beat was lost or changed");

    // masked output beat is black
    a_mask_black: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !mask_reg[PIPE_DEPTH-1] |-> blue == 8'd0 && green == 8'd0 && red == 8'd0)
        else $error("masked pixel is not black");

endmodule
`default_nettype wire

### rtl/pdbm_lane.sv
// one color lane: float bits to dB, window clamp and 8-bit scaling
`default_nettype none
module pdbm_lane #(
    parameter int LOG_TABLE_BITS = 10
) (
    input  wire logic                              clk,
    input  wire logic [pdbm_pkg::PIPE_DEPTH-1:0]   stage_en,
    input  wire pdbm_pkg::win_cfg_t                win,
    input  wire logic [31:0]                       t_bits,
    output logic      [pdbm_pkg::LVL_W-1:0]        level
);
    import pdbm_pkg::*;

    localparam int TABLE_SIZE = 1 << LOG_TABLE_BITS;

    // constant log table, built at elaboration
    logic [TAB_W-1:0] log_rom [TABLE_SIZE];

    for (genvar k = 0; k < TABLE_SIZE; k++) begin : g_rom
        assign log_rom[k] = log_tab_entry(k, LOG_TABLE_BITS);
    end

    // stage 0: split the float pattern, sign dropped
    logic [7:0]                exp_reg;
    logic [LOG_TABLE_BITS-1:0] idx_reg;
    logic                      zero0_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            exp_reg   <= t_bits[30:23];
            idx_reg   <= t_bits[22 -: LOG_TABLE_BITS];
            zero0_reg <= (t_bits[30:23] == 8'd0);
        end
    end

    // stage 1: table read and octave term
    logic signed [9:0]      exp_s;
    logic signed [DB_W-1:0] oct_next;
    logic signed [DB_W-1:0] oct_reg;
    logic [TAB_W-1:0]       tab_reg;
    logic                   zero1_reg;

    assign exp_s    = $signed({2'b00, exp_reg}) - EXP_BIAS;
    assign oct_next = DB_W'(exp_s) * DB_PER_OCTAVE;

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            oct_reg   <= oct_next;
            tab_reg   <= log_rom[idx_reg];
            zero1_reg <= zero0_reg;
        end
    end

    // stage 2: raw dB, zero and denormal go to the floor
    logic signed [DB_W-1:0] db_next;
    logic signed [DB_W-1:0] db_reg;

    assign db_next = zero1_reg ? DB_W'(win.floor_db)
                               : oct_reg + $signed({{(DB_W - TAB_W){1'b0}}, tab_reg});

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
            db_reg <= db_next;
    end

    // stage 3: floor, upper and lower clamps, offset from lower limit
    logic signed [DB_W-1:0] lo_db;
    logic signed [DB_W-1:0] hi_db;
    logic signed [DB_W-1:0] mn_db;
    logic signed [DB_W-1:0] d_floor;
    logic signed [DB_W-1:0] d_max;
    logic signed [DB_W-1:0] d_min;
    logic signed [DB_W-1:0] d_off;
    logic [DIFF_W-1:0]      diff_next;
    logic [DIFF_W-1:0]      diff_reg;

    assign lo_db     = DB_W'(win.floor_db);
    assign hi_db     = DB_W'(win.max_db);
    assign mn_db     = DB_W'(win.min_db);
    assign d_floor   = (db_reg < lo_db) ? lo_db : db_reg;
    assign d_max     = (d_floor > hi_db) ? hi_db : d_floor;
    assign d_min     = (d_max < mn_db) ? mn_db : d_max;
    assign d_off     = d_min - mn_db;
    assign diff_next = d_off[DIFF_W-1:0];

    always_ff @(posedge clk)
    begin
        if (stage_en[3])
            diff_reg <= diff_next;
    end

    // stage 4: scale multiply
    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[4])
            prod_reg <= PROD_W'(diff_reg) * PROD_W'(win.scale_factor);
    end

    // stage 5: drop the Q16 fraction and saturate
    logic [LVL_W-1:0] level_next;
    logic [LVL_W-1:0] level_reg;

    assign level_next = (|prod_reg[PROD_W-1:16 + LVL_W]) ? {LVL_W{1'b1}}
                                                          : prod_reg[16 + LVL_W - 1:16];

    always_ff @(posedge clk)
    begin
        if (stage_en[5])
            level_reg <= level_next;
    end

    assign level = level_reg;

endmodule
`default_nettype wire

### test/pauli_db_rgb_pixel_mapper_tb.sv
// testbench for the pauli dB rgb pixel mapper: predicted colors checked per beat
`timescale 1ns / 100ps

module pauli_db_rgb_pixel_mapper_tb;

    import pdbm_pkg::*;

    localparam int TABLE_BITS = 10;
    localparam int OCTAVE_DB  = 771;
    localparam int EXP_ZERO   = 127;

    typedef struct {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } color_t;

    // predicts the color of each accepted pixel and checks output beats in order
    class pixel_color_board;
        int     lo_db;
        int     hi_db;
        int     gain;
        int     floor_db;
        int     db_table[1 << TABLE_BITS];
        color_t pending_colors[$];
        int     mismatches;

        // fractional log2 by repeated squaring, Q30 in and out
        function longint unsigned frac_log2(longint unsigned m_in);
            longint unsigned m;
            longint unsigned r;
            m = m_in;
            r = 0;
            for (int i = 0; i < 30; i++)
            begin
                m = (m * m) >> 30;
                r = r << 1;
                if (m >= (64'd2 << 30))
                begin
                    m = m >> 1;
                    r = r | 64'd1;
                end
            end
            return r;
        endfunction

        function new();
            longint unsigned den;
            longint unsigned num;
            longint unsigned m;
            // log2(10) in Q30 as the divisor of the dB table
            den = 3 * (64'd1 << 30) + frac_log2(64'd5 << 28);
            for (int k = 0; k < (1 << TABLE_BITS); k++)
            begin
                m = (64'd1 << 30) + (64'(k) << (30 - TABLE_BITS));
                num = 64'd2560 * frac_log2(m);
                db_table[k] = int'((2 * num + den) / (2 * den));
            end
            // window after reset
            lo_db      = -7680;
            hi_db      = 0;
            gain       = 2176;
            floor_db   = -32768;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [SCL_W-1:0] word);
            case (idx)
                CFG_MIN_DB:   lo_db    = int'($signed(word[15:0]));
                CFG_MAX_DB:   hi_db    = int'($signed(word[15:0]));
                CFG_SCALE:    gain     = int'(word);
                CFG_FLOOR_DB: floor_db = int'($signed(word[15:0]));
                default: ;
            endcase
        endfunction

        // one power term to an 8-bit level
        function logic [7:0] term_level(logic [31:0] bits);
            int     ex;
            int     db;
            longint prod;
            ex = int'(bits[30:23]);
            if (ex == 0)
                db = floor_db;
            else
                db = (ex - EXP_ZERO) * OCTAVE_DB + db_table[bits[22:23-TABLE_BITS]];
            if (db < floor_db)
                db = floor_db;
            if (db > hi_db)
                db = hi_db;
            if (db < lo_db)
                db = lo_db;
            prod = (longint'(db - lo_db) * longint'(gain)) >>> 16;
            return (prod > 255) ? 8'd255 : prod[7:0];
        endfunction

        function void note_pixel(logic [31:0] t11, logic [31:0] t22, logic [31:0] t33,
                                 logic pv);
            color_t c;
            if (pv)
            begin
                c.blue  = term_level(t11);
                c.green = term_level(t33);
                c.red   = term_level(t22);
            end
            else
            begin
                c.blue  = 8'd0;
                c.green = 8'd0;
                c.red   = 8'd0;
            end
            pending_colors.push_back(c);
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_color(logic [7:0] b, logic [7:0] g, logic [7:0] r);
            color_t want;
            if (pending_colors.size() == 0)
            begin
                report_mismatch("color beat with no pixel pending");
                return;
            end
            want = pending_colors.pop_front();
            if (b !== want.blue)
                report_mismatch($sformatf("blue got %0d want %0d", b, want.blue));
            if (g !== want.green)
                report_mismatch($sformatf("green got %0d want %0d", g, want.green));
            if (r !== want.red)
                report_mismatch($sformatf("red got %0d want %0d", r, want.red));
        endtask
    endclass

    logic                 clk;
    logic                 rst_n        = 1'b0;
    logic                 cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = CFG_MIN_DB;
    logic [SCL_W-1:0]     cfg_data     = '0;
    logic                 item_valid   = 1'b0;
    logic                 item_ready;
    logic [31:0]          t11_bits     = '0;
    logic [31:0]          t22_bits     = '0;
    logic [31:0]          t33_bits     = '0;
    logic                 pixel_valid  = 1'b0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    logic [7:0]           blue;
    logic [7:0]           green;
    logic [7:0]           red;

    logic                 rx_hold       = 1'b0;
    int                   send_idle_pct = 14;
    int                   recv_idle_pct = 77;
    pixel_color_board     board;

    pauli_db_rgb_pixel_mapper #(
        .LOG_TABLE_BITS(TABLE_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .t11_bits    (t11_bits),
        .t22_bits    (t22_bits),
        .t33_bits    (t33_bits),
        .pixel_valid (pixel_valid),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .blue        (blue),
        .green       (green),
        .red         (red)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("pauli_db_rgb_pixel_mapper test failed");
        $finish;
    end

    // output side: check each color beat, then pick the next ready
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            board.check_color(blue, green, red);
        result_ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // offer one pixel beat and hold it until it is taken
    task automatic send_pixel(logic [31:0] t11, logic [31:0] t22, logic [31:0] t33,
                              logic pv);
        // idle cycles drawn one at a time
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid  <= 1'b1;
        t11_bits    <= t11;
        t22_bits    <= t22;
        t33_bits    <= t33;
        pixel_valid <= pv;
        do
            @(posedge clk);
        while (!item_ready);
        board.note_pixel(t11, t22, t33, pv);
    endtask

    // power term aimed mostly at the current display window
    function automatic logic [31:0] rand_term();
        int          pick;
        int          lo;
        int          span;
        int          target;
        int          ex;
        logic        sgn;
        logic [22:0] mant;
        pick = $urandom_range(99);
        sgn  = 1'($urandom);
        mant = 23'($urandom);
        if (pick < 8)
            return {sgn, 8'h00, mant};
        if (pick < 12)
            return {sgn, 8'hFF, mant};
        if (pick < 30)
            return $urandom;
        lo   = (board.lo_db < board.hi_db) ? board.lo_db : board.hi_db;
        span = board.hi_db - board.lo_db;
        span = ((span < 0) ? -span : span) + 3200;
        target = lo - 1600 + int'($urandom_range(span));
        ex = EXP_ZERO + target / OCTAVE_DB;
        if (ex < 1)
            ex = 1;
        if (ex > 254)
            ex = 254;
        return {sgn, 8'(ex), mant};
    endfunction

    task automatic run_pixels(int count);
        for (int i = 0; i < count; i++)
            send_pixel(rand_term(), rand_term(), rand_term(), $urandom_range(99) < 90);
    endtask

    // stop offering and wait until every predicted color has come back
    task automatic drain();
        item_valid <= 1'b0;
        while (board.pending_colors.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SCL_W-1:0] word);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        @(posedge clk);
        board.set_reg(idx, word);
    endtask

    // write the whole window, upper data bits of the dB registers are don't care
    task automatic set_window(int lo, int hi, int scl, int fl);
        write_reg(CFG_MIN_DB,   {8'($urandom), 16'(lo)});
        write_reg(CFG_MAX_DB,   {8'($urandom), 16'(hi)});
        write_reg(CFG_SCALE,    24'(scl));
        write_reg(CFG_FLOOR_DB, {8'($urandom), 16'(fl)});
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // plausible window with a roughly matching scale
    task automatic random_window();
        int lo;
        int hi;
        int scl;
        int fl;
        lo  = int'($urandom_range(12000)) - 14000;
        hi  = lo + 300 + int'($urandom_range(9000));
        scl = (255 * 65536) / (hi - lo) + int'($urandom_range(64)) - 32;
        fl  = lo - 2000 + int'($urandom_range(3000));
        set_window(lo, hi, scl, fl);
    endtask

    initial
    begin
        board = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pixels on the reset window
        send_pixel(32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 1'b1);
        send_pixel(32'h007F_FFFF, 32'h0080_0000, 32'h3F80_0000, 1'b1);
        send_pixel(32'h7F80_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_pixel(32'hBF80_0000, 32'h3FFF_FFFF, 32'h3F00_0000, 1'b1);
        send_pixel(32'h3A83_126F, 32'h3C23_D70A, 32'h3DCC_CCCD, 1'b1);
        send_pixel(32'h3A80_0000, 32'h3A7F_FFFF, 32'h4000_0000, 1'b1);
        send_pixel(32'h3F80_0000, 32'h7F80_0000, 32'h3DCC_CCCD, 1'b0);
        send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_pixel(32'h0080_0000, 32'h7F7F_FFFF, 32'h3F7F_FFFF, 1'b1);
        send_pixel(32'h5555_5555, 32'hAAAA_AAAA, 32'h3B00_0000, 1'b1);
        drain();

        // sender idles lightly, receiver mostly stalls
        random_window();
        run_pixels(140);
        // receiver holds off while pixels keep coming, so the pipe fills
        fork
            begin
                @(posedge clk);
                rx_hold <= 1'b1;
                repeat (300) @(posedge clk);
                rx_hold <= 1'b0;
            end
            run_pixels(60);
        join
        drain();

        // sender mostly idles, receiver lightly
        send_idle_pct = 77;
        recv_idle_pct <= 14;
        // widest window with the largest scale
        set_window(-32768, 32767, 24'hFF_FFFF, -32768);
        run_pixels(12);
        drain();
        // inverted window, every level is zero
        set_window(32767, -32768, 24'h12_3456, 32767);
        run_pixels(10);
        drain();
        // empty window and zero scale
        set_window(-5000, -5000, 0, -20000);
        run_pixels(8);
        drain();
        // floor above the window
        set_window(-9000, -3000, 2785, -1000);
        run_pixels(8);
        drain();
        // highest floor under a wide window
        set_window(-32768, 0, 510, 32767);
        run_pixels(8);
        drain();
        random_window();
        run_pixels(150);
        drain();

        // no idling on either side
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        random_window();
        run_pixels(120);
        drain();
        random_window();
        run_pixels(100);
        drain();

        if (board.mismatches == 0)
            $display("pauli_db_rgb_pixel_mapper test passed");
        else
            $display("pauli_db_rgb_pixel_mapper test failed");
        $finish;
    end

endmodule

### files.f
rtl/pdbm_pkg.sv
rtl/pdbm_lane.sv
rtl/pauli_db_rgb_pixel_mapper.sv
test/pauli_db_rgb_pixel_mapper_tb.sv
